### sv/msc_pkg.sv
// Package for the motor speed command framer.
// Holds the transaction types, function and register codes, frame constants and CRC step.
// No dependencies; every other file of the block imports it.
package msc_pkg;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       left_clamped;
        logic       right_clamped;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] left_mag;
        logic [7:0] right_mag;
        logic [7:0] flags;
        logic       left_clamped;
        logic       right_clamped;
    } frame_fields_t;

    localparam logic [1:0] FUNC_SET_BOTH  = 2'd0;
    localparam logic [1:0] FUNC_SET_LEFT  = 2'd1;
    localparam logic [1:0] FUNC_SET_RIGHT = 2'd2;
    localparam logic [1:0] FUNC_SEND      = 2'd3;

    localparam logic CFG_CLOSED_LOOP = 1'b0;
    localparam logic CFG_PID_PERIOD  = 1'b1;

    localparam logic signed [15:0] SPEED_LIMIT = 16'sd240;

    localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
    localparam logic [7:0]  LENGTH_BYTE = 8'h07;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [3:0] POS_SYNC     = 4'd0;
    localparam logic [3:0] POS_LENGTH   = 4'd1;
    localparam logic [3:0] POS_LEFT_LO  = 4'd2;
    localparam logic [3:0] POS_LEFT_HI  = 4'd3;
    localparam logic [3:0] POS_RIGHT_LO = 4'd4;
    localparam logic [3:0] POS_RIGHT_HI = 4'd5;
    localparam logic [3:0] POS_FLAGS    = 4'd6;
    localparam logic [3:0] POS_CRC_LO   = 4'd7;
    localparam logic [3:0] POS_CRC_HI   = 4'd8;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/msc_cmd_reg.sv
// Input register of the motor speed command framer.
// Holds one command transaction until the core takes it; depends on msc_pkg.
module msc_cmd_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  msc_pkg::cmd_item_t cmd,
    input  logic              take,
    output logic              pend_valid,
    output msc_pkg::cmd_item_t pend
);
    import msc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_item_t item_reg;
    logic      accept;

    assign cmd_stall  = valid_reg && !take;
    assign accept     = cmd_valid && !cmd_stall;
    assign pend_valid = valid_reg;
    assign pend       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) take |-> valid_reg)
        else $error("Command taken from an empty input register.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !take) |=> (valid_reg && $stable(item_reg)))
        else $error("Pending command lost or changed before it was taken.");
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> valid_reg)
        else $error("Accepted command not held.");

endmodule

### sv/msc_speed_hold.sv
// Held wheel speeds, configuration registers and frame field computation.
// Saturates on a send and forms magnitudes, flags and clamp bits; depends on msc_pkg.
module msc_speed_hold (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic                  cfg_data,
    input  logic                  take,
    input  msc_pkg::cmd_item_t     pend,
    output msc_pkg::frame_fields_t fields
);
    import msc_pkg::*;

    logic               closed_loop_reg;
    logic               pid_period_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] left_next;
    logic signed [15:0] right_reg;
    logic signed [15:0] right_next;
    logic               left_hi;
    logic               left_lo;
    logic               right_hi;
    logic               right_lo;
    logic signed [15:0] left_sat;
    logic signed [15:0] right_sat;
    logic signed [15:0] left_neg;
    logic signed [15:0] right_neg;

    assign left_hi  = left_reg > SPEED_LIMIT;
    assign left_lo  = left_reg < -SPEED_LIMIT;
    assign right_hi = right_reg > SPEED_LIMIT;
    assign right_lo = right_reg < -SPEED_LIMIT;

    assign left_sat  = left_hi ? SPEED_LIMIT : (left_lo ? -SPEED_LIMIT : left_reg);
    assign right_sat = right_hi ? SPEED_LIMIT : (right_lo ? -SPEED_LIMIT : right_reg);
    assign left_neg  = -left_sat;
    assign right_neg = -right_sat;

    always_comb
    begin
        fields.left_mag      = left_sat[15] ? left_neg[7:0] : left_sat[7:0];
        fields.right_mag     = right_sat[15] ? right_neg[7:0] : right_sat[7:0];
        fields.flags         = {closed_loop_reg, !left_sat[15], closed_loop_reg,
                                !right_sat[15], !pid_period_reg, 2'b00, 1'b1};
        fields.left_clamped  = left_hi || left_lo;
        fields.right_clamped = right_hi || right_lo;
    end

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (take)
        begin
            unique case (pend.func)
                FUNC_SET_BOTH:
                begin
                    left_next  = pend.left_speed;
                    right_next = pend.right_speed;
                end
                FUNC_SET_LEFT:
                begin
                    left_next = pend.left_speed;
                end
                FUNC_SET_RIGHT:
                begin
                    right_next = pend.right_speed;
                end
                FUNC_SEND:
                begin
                    left_next  = left_sat;
                    right_next = right_sat;
                end
                default:
                begin
                    left_next  = left_reg;
                    right_next = right_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg <= 1'b1;
            pid_period_reg  <= 1'b1;
            left_reg        <= '0;
            right_reg       <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            if (cfg_we && cfg_index == CFG_CLOSED_LOOP)
            begin
                closed_loop_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_PID_PERIOD)
            begin
                pid_period_reg <= cfg_data;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && pend.func == FUNC_SEND) |=>
        (left_reg <= SPEED_LIMIT && left_reg >= -SPEED_LIMIT &&
         right_reg <= SPEED_LIMIT && right_reg >= -SPEED_LIMIT))
        else $error("Held speed outside the limit after a send.");
    assert property (@(posedge clk) disable iff (!rst_n) !take |=> $stable(left_reg))
        else $error("Left speed changed without a command.");
    assert property (@(posedge clk) disable iff (!rst_n)
        fields.flags[7] == fields.flags[5] && fields.flags[0])
        else $error("Flags byte malformed.");

endmodule

### sv/msc_serializer.sv
// Frame serializer: output register, byte position counter and running CRC.
// Emits the nine frame bytes one per transaction; depends on msc_pkg.
module msc_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  msc_pkg::frame_fields_t fields,
    output logic                  ready,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output msc_pkg::frame_item_t   frame
);
    import msc_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    frame_item_t   item_reg;
    frame_item_t   item_next;
    logic [3:0]    pos_reg;
    logic [3:0]    pos_next;
    logic [3:0]    pos_inc;
    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic [15:0]   crc_step;
    frame_fields_t fields_reg;
    logic          out_accept;
    logic          crc_covers;

    assign out_accept  = valid_reg && !frame_stall;
    assign ready       = !valid_reg || (out_accept && pos_reg == POS_CRC_HI);
    assign frame_valid = valid_reg;
    assign frame       = item_reg;
    assign pos_inc     = pos_reg + 4'd1;
    assign crc_step    = crc_byte(crc_reg, item_reg.frame_byte);
    assign crc_covers  = pos_reg >= POS_LENGTH && pos_reg <= POS_FLAGS;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        if (load)
        begin
            valid_next              = 1'b1;
            pos_next                = POS_SYNC;
            crc_next                = CRC_INIT;
            item_next.frame_byte    = SYNC_BYTE;
            item_next.last_byte     = 1'b0;
            item_next.left_clamped  = fields.left_clamped;
            item_next.right_clamped = fields.right_clamped;
        end
        else if (out_accept)
        begin
            if (pos_reg == POS_CRC_HI)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                pos_next            = pos_inc;
                item_next.last_byte = pos_inc == POS_CRC_HI;
                if (crc_covers)
                begin
                    crc_next = crc_step;
                end
                unique case (pos_inc)
                    POS_LENGTH:   item_next.frame_byte = LENGTH_BYTE;
                    POS_LEFT_LO:  item_next.frame_byte = fields_reg.left_mag;
                    POS_LEFT_HI:  item_next.frame_byte = 8'h00;
                    POS_RIGHT_LO: item_next.frame_byte = fields_reg.right_mag;
                    POS_RIGHT_HI: item_next.frame_byte = 8'h00;
                    POS_FLAGS:    item_next.frame_byte = fields_reg.flags;
                    POS_CRC_LO:   item_next.frame_byte = crc_step[7:0];
                    POS_CRC_HI:   item_next.frame_byte = crc_reg[15:8];
                    default:      item_next.frame_byte = item_reg.frame_byte;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= POS_CRC_HI;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        crc_reg  <= crc_next;
        if (load)
        begin
            fields_reg <= fields;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) load |-> ready)
        else $error("Frame loaded while the previous one is still going out.");
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && pos_reg == POS_SYNC && item_reg.frame_byte == SYNC_BYTE))
        else $error("Frame did not start with the sync byte.");
    assert property (@(posedge clk) disable iff (!rst_n) !valid_reg |-> pos_reg == POS_CRC_HI)
        else $error("Serializer idle in mid frame.");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (item_reg.last_byte == (pos_reg == POS_CRC_HI)))
        else $error("Last byte mark out of step with position.");

endmodule

### sv/motor_speed_command_framer_unit.sv
// Top level of the motor speed command framer: input register, speed hold, serializer.
// Depends on msc_pkg, msc_cmd_reg, msc_speed_hold and msc_serializer.
// A send accepted while no frame is going out passes the input register and the serializer
// output register before its first byte is valid. Updates go one per cycle while no send
// waits; a send puts out nine bytes through the byte-wide output register, one per transfer;
// a waiting send is loaded in the same cycle as the previous frame's last byte is accepted.
// Reset: speeds clear to zero, both configuration bits set to one, both channels empty.
module motor_speed_command_framer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  msc_pkg::cmd_item_t   cmd,
    output logic                frame_valid,
    input  logic                frame_stall,
    output msc_pkg::frame_item_t frame,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic                cfg_data
);
    import msc_pkg::*;

    logic          pend_valid;
    cmd_item_t     pend;
    logic          take;
    logic          load;
    logic          ser_ready;
    frame_fields_t fields;

    assign take = pend_valid && (pend.func != FUNC_SEND || ser_ready);
    assign load = take && pend.func == FUNC_SEND;

    msc_cmd_reg u_cmd_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .take       (take),
        .pend_valid (pend_valid),
        .pend       (pend)
    );

    msc_speed_hold u_speed_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .pend      (pend),
        .fields    (fields)
    );

    msc_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .fields      (fields),
        .ready       (ser_ready),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid && pend.func != FUNC_SEND) |-> take)
        else $error("Speed update held back.");
    assert property (@(posedge clk) disable iff (!rst_n) load |=> frame_valid)
        else $error("Send transaction produced no frame.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_stall) |=> (frame_valid && $stable(frame)))
        else $error("Stalled frame byte changed.");

endmodule

### verif/tb_motor_speed_command_framer_unit.sv
// Testbench for motor_speed_command_framer_unit: drives speed updates, send ticks and register
// writes, predicts every frame byte and its clamp flags, and checks each result transaction.
// Depends on msc_pkg and the RTL of the framer.
`timescale 1ns / 1ps

module tb_motor_speed_command_framer_unit;
    import msc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_item_t   cmd = '0;
    logic        frame_valid;
    logic        frame_stall = 1'b0;
    frame_item_t frame;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_CLOSED_LOOP;
    logic        cfg_data = 1'b0;

    logic               closed_loop_bit = 1'b1;
    logic               pid_period_bit = 1'b1;
    logic signed [15:0] left_hold = '0;
    logic signed [15:0] right_hold = '0;
    frame_item_t        frame_expect_q[$];

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold = 0;
    int fail_count = 0;

    motor_speed_command_framer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("[motor_speed_command_framer_unit] ERROR");
        $finish;
    end

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] modbus_crc(input logic [47:0] payload);
        logic [15:0] crc;
        logic        fb;
        crc = CRC_INIT;
        for (int i = 0; i < 48; i++)
        begin
            fb = crc[0] ^ payload[i];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic signed [15:0] saturate(input logic signed [15:0] v, output logic hit);
        hit = 1'b0;
        if (v > SPEED_LIMIT)
        begin
            hit = 1'b1;
            return SPEED_LIMIT;
        end
        if (v < -SPEED_LIMIT)
        begin
            hit = 1'b1;
            return -SPEED_LIMIT;
        end
        return v;
    endfunction

    task automatic predict_frame();
        logic        lc;
        logic        rc;
        logic [15:0] lmag;
        logic [15:0] rmag;
        logic [7:0]  flags;
        logic [15:0] crc;
        logic [7:0]  bytes [0:8];
        frame_item_t item;
        left_hold = saturate(left_hold, lc);
        right_hold = saturate(right_hold, rc);
        lmag = left_hold[15] ? -left_hold : left_hold;
        rmag = right_hold[15] ? -right_hold : right_hold;
        flags = 8'h01;
        flags[7] = closed_loop_bit;
        flags[5] = closed_loop_bit;
        flags[6] = ~left_hold[15];
        flags[4] = ~right_hold[15];
        flags[3] = ~pid_period_bit;
        bytes[POS_SYNC] = SYNC_BYTE;
        bytes[POS_LENGTH] = LENGTH_BYTE;
        bytes[POS_LEFT_LO] = lmag[7:0];
        bytes[POS_LEFT_HI] = lmag[15:8];
        bytes[POS_RIGHT_LO] = rmag[7:0];
        bytes[POS_RIGHT_HI] = rmag[15:8];
        bytes[POS_FLAGS] = flags;
        crc = modbus_crc({flags, rmag, lmag, LENGTH_BYTE});
        bytes[POS_CRC_LO] = crc[7:0];
        bytes[POS_CRC_HI] = crc[15:8];
        for (int k = 0; k < 9; k++)
        begin
            item.frame_byte = bytes[k];
            item.last_byte = (k == POS_CRC_HI);
            item.left_clamped = lc;
            item.right_clamped = rc;
            frame_expect_q.push_back(item);
        end
    endtask

    task automatic predict_cmd(input cmd_item_t c);
        case (c.func)
            FUNC_SET_BOTH:
            begin
                left_hold = c.left_speed;
                right_hold = c.right_speed;
            end
            FUNC_SET_LEFT:  left_hold = c.left_speed;
            FUNC_SET_RIGHT: right_hold = c.right_speed;
            default:        predict_frame();
        endcase
    endtask

    always @(posedge clk)
    begin
        frame_item_t exp_item;
        if (rst_n && frame_valid && !frame_stall)
        begin
            rx_hold = draw_wait(rx_quiet);
            if (frame_expect_q.size() == 0)
            begin
                $error("frame: unexpected transaction, frame_byte %0h", frame.frame_byte);
                fail_count++;
            end
            else
            begin
                exp_item = frame_expect_q.pop_front();
                if (frame.frame_byte !== exp_item.frame_byte)
                begin
                    $error("frame_byte expected %0h actual %0h",
                           exp_item.frame_byte, frame.frame_byte);
                    fail_count++;
                end
                if (frame.last_byte !== exp_item.last_byte)
                begin
                    $error("last_byte expected %0b actual %0b",
                           exp_item.last_byte, frame.last_byte);
                    fail_count++;
                end
                if (frame.left_clamped !== exp_item.left_clamped)
                begin
                    $error("left_clamped expected %0b actual %0b",
                           exp_item.left_clamped, frame.left_clamped);
                    fail_count++;
                end
                if (frame.right_clamped !== exp_item.right_clamped)
                begin
                    $error("right_clamped expected %0b actual %0b",
                           exp_item.right_clamped, frame.right_clamped);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            frame_stall = 1'b1;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            frame_stall = 1'b0;
        end
    end

    task automatic send_cmd(input logic [1:0] f, input logic signed [15:0] l,
                            input logic signed [15:0] r);
        int        gap;
        cmd_item_t item;
        gap = draw_wait(tx_quiet);
        item.func = f;
        item.left_speed = l;
        item.right_speed = r;
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            cmd = cmd_item_t'({2'($urandom), $urandom});
            repeat (gap) @(negedge clk);
        end
        cmd = item;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        predict_cmd(item);
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_valid = 1'b0;
        while (frame_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic configure(input logic loop_on, input logic pid_sel);
        drain();
        cfg_we = 1'b1;
        cfg_index = CFG_CLOSED_LOOP;
        cfg_data = loop_on;
        @(negedge clk);
        closed_loop_bit = loop_on;
        cfg_index = CFG_PID_PERIOD;
        cfg_data = pid_sel;
        @(negedge clk);
        pid_period_bit = pid_sel;
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            2: return 16'($urandom_range(0, 480) - 240);
            3: return 16'($urandom_range(0, 1) ? $urandom_range(237, 244)
                                                : -$urandom_range(237, 244));
            default: return 16'($urandom_range(0, 600) - 300);
        endcase
    endfunction

    task automatic test_reset_state();
        send_cmd(FUNC_SEND, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_speed_extremes();
        send_cmd(FUNC_SET_BOTH, 16'sh7FFF, 16'sh8000);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SEND, 16'sh1234, 16'sh4321);
        send_cmd(FUNC_SET_BOTH, 16'sh8000, 16'sh7FFF);
        send_cmd(FUNC_SEND, 16'shFFFF, 16'shFFFF);
        send_cmd(FUNC_SET_BOTH, 16'sd240, -16'sd240);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SET_BOTH, 16'sd241, -16'sd241);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SET_BOTH, -16'sd1, 16'sd0);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SET_LEFT, 16'sd100, 16'sh7FFF);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SET_RIGHT, 16'sh8000, -16'sd55);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SET_LEFT, -16'sd240, 16'sd0);
        send_cmd(FUNC_SET_RIGHT, 16'sd0, 16'sd239);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_config_settings();
        for (int k = 0; k < 4; k++)
        begin
            configure(k[1], k[0]);
            send_cmd(FUNC_SET_BOTH, pick_speed(), pick_speed());
            send_cmd(FUNC_SEND, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int sel;
        for (int p = 0; p < 8; p++)
        begin
            configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 55; n++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 3)
                begin
                    send_cmd(FUNC_SET_BOTH, pick_speed(), pick_speed());
                end
                else if (sel < 5)
                begin
                    send_cmd(FUNC_SET_LEFT, pick_speed(), 16'($urandom));
                end
                else if (sel < 7)
                begin
                    send_cmd(FUNC_SET_RIGHT, 16'($urandom), pick_speed());
                end
                else
                begin
                    send_cmd(FUNC_SEND, 16'($urandom), 16'($urandom));
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_state();
        test_speed_extremes();
        test_config_settings();
        test_random_traffic();
        configure(1'b1, 1'b1);
        send_cmd(FUNC_SEND, 16'sh0000, 16'sh0000);
        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("[motor_speed_command_framer_unit] OK");
        end
        else
        begin
            $display("[motor_speed_command_framer_unit] ERROR");
        end
        $finish;
    end

endmodule

### motor_speed_command_framer_unit.f
sv/msc_pkg.sv
sv/msc_cmd_reg.sv
sv/msc_speed_hold.sv
sv/msc_serializer.sv
sv/motor_speed_command_framer_unit.sv
verif/tb_motor_speed_command_framer_unit.sv
